// ----- rtl/sws_pkg.sv -----
// Shared types, constants and the digit parsing function for the scale frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package sws_pkg;

    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [4:0] FRAME_LEN   = 5'd18;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    localparam logic [4:0] POS_STATUS_A    = 5'd1;
    localparam logic [4:0] POS_STATUS_B    = 5'd2;
    localparam logic [4:0] POS_WEIGHT_HEAD = 5'd4;
    localparam logic [4:0] POS_WEIGHT_TAIL = 5'd9;
    localparam logic [4:0] POS_TARE_HEAD   = 5'd10;
    localparam logic [4:0] POS_TARE_TAIL   = 5'd15;

    localparam logic [2:0] MODE_ONE_DEC   = 3'd3;
    localparam logic [2:0] MODE_TWO_DEC   = 3'd4;
    localparam logic [2:0] MODE_THREE_DEC = 3'd5;

    localparam int VALUE_W = 20;
    localparam int MILLI_W = 30;
    localparam int TDATA_W = 56;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               started;
        logic               stopped;
    } t_num;

    typedef struct packed {
        logic [VALUE_W-1:0] weight;
        logic [VALUE_W-1:0] tare;
        logic [2:0]         mode;
        logic               unit_kg;
    } t_frame;

    typedef struct packed {
        logic               unit_changed;
        logic               tare_changed;
        logic               weight_changed;
        logic               unit_kg;
        logic               value_valid;
        logic [2:0]         mode_code;
        logic [1:0]         decimals;
        logic [VALUE_W-1:0] tare_raw;
        logic [VALUE_W-1:0] weight_raw;
    } t_result;

    // Feeds one byte to an ASCII decimal field.
    function automatic t_num parse_digit(input logic [7:0] b, input t_num cur);
        t_num nxt;
        nxt = cur;
        if (!cur.stopped) begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                nxt.acc = (cur.acc << 3) + (cur.acc << 1) + VALUE_W'(b[3:0]);
                nxt.started = 1'b1;
            end else if (b == ASCII_SPACE && !cur.started) begin
                nxt.stopped = 1'b0;
            end else begin
                nxt.stopped = 1'b1;
            end
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sws_parser.sv -----
// Byte-level frame tracker: position, checksum, status bytes and digit fields.
// Depends on sws_pkg; holds one finished frame until the publish stage takes it.
`default_nettype none

module sws_parser
    import sws_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_frm_valid,
    output t_frame          o_frm
);

    logic       r_in_frame, n_in_frame;
    logic [4:0] r_pos, n_pos;
    logic [6:0] r_sum, n_sum;
    logic [2:0] r_sa, n_sa;
    logic [1:0] r_sb, n_sb;
    t_num       r_wnum, n_wnum;
    t_num       r_tnum, n_tnum;
    logic       r_frm_valid;
    t_frame     r_frm;
    logic       c_start;
    logic       c_emit;
    logic [4:0] c_pos_inc;

    always_comb begin
        c_start    = (i_byte == FRAME_START);
        n_in_frame = r_in_frame | c_start;
        n_pos      = c_start ? '0 : r_pos;
        n_sum      = c_start ? '0 : r_sum;
        n_sa       = c_start ? '0 : r_sa;
        n_sb       = c_start ? '0 : r_sb;
        n_wnum     = c_start ? '0 : r_wnum;
        n_tnum     = c_start ? '0 : r_tnum;
        c_pos_inc  = n_pos + 5'd1;
        c_emit     = 1'b0;
        if (n_in_frame) begin
            n_sum = n_sum + i_byte[6:0];
            if (n_pos == POS_STATUS_A) begin
                n_sa = i_byte[2:0];
            end else if (n_pos == POS_STATUS_B) begin
                n_sb = {i_byte[4], i_byte[2]};
            end else if (n_pos >= POS_WEIGHT_HEAD && n_pos <= POS_WEIGHT_TAIL) begin
                n_wnum = parse_digit(i_byte, n_wnum);
            end else if (n_pos >= POS_TARE_HEAD && n_pos <= POS_TARE_TAIL) begin
                n_tnum = parse_digit(i_byte, n_tnum);
            end
            if (c_pos_inc == FRAME_LEN) begin
                c_emit     = (n_sum == 7'd0) && !n_sb[0];
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_sum      = '0;
            end else begin
                n_pos = c_pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_sa        <= '0;
            r_sb        <= '0;
            r_wnum      <= '0;
            r_tnum      <= '0;
            r_frm_valid <= 1'b0;
        end else begin
            if (i_valid) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
                r_sum      <= n_sum;
                r_sa       <= n_sa;
                r_sb       <= n_sb;
                r_wnum     <= n_wnum;
                r_tnum     <= n_tnum;
            end
            if (i_valid && c_emit) begin
                r_frm_valid <= 1'b1;
            end else if (i_take) begin
                r_frm_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && c_emit) begin
            r_frm.weight  <= n_wnum.acc;
            r_frm.tare    <= n_tnum.acc;
            r_frm.mode    <= n_sa;
            r_frm.unit_kg <= n_sb[1];
        end
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

endmodule

`default_nettype wire

// ----- rtl/sws_publish.sv -----
// Decodes the mode, scales values to thousandths and compares with the last published frame.
// Depends on sws_pkg; feeds the output buffer.
`default_nettype none

module sws_publish
    import sws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_frm_valid,
    input  wire t_frame  i_frm,
    input  wire logic    i_buf_full,
    output logic         o_take,
    output t_result      o_result
);

    logic [MILLI_W-1:0] r_last_w, r_last_t;
    logic               r_last_unit;
    logic               c_valid;
    logic [1:0]         c_dec;
    logic [MILLI_W-1:0] c_mul;
    logic [MILLI_W-1:0] c_wm, c_tm;

    always_comb begin
        c_valid = 1'b1;
        c_dec   = 2'd0;
        c_mul   = MILLI_W'(1);
        case (i_frm.mode)
            MODE_ONE_DEC: begin
                c_dec = 2'd1;
                c_mul = MILLI_W'(100);
            end
            MODE_TWO_DEC: begin
                c_dec = 2'd2;
                c_mul = MILLI_W'(10);
            end
            MODE_THREE_DEC: begin
                c_dec = 2'd3;
            end
            default: begin
                c_valid = 1'b0;
            end
        endcase
        c_wm = MILLI_W'(i_frm.weight) * c_mul;
        c_tm = MILLI_W'(i_frm.tare) * c_mul;

        o_result.weight_raw     = i_frm.weight;
        o_result.tare_raw       = i_frm.tare;
        o_result.decimals       = c_dec;
        o_result.mode_code      = i_frm.mode;
        o_result.value_valid    = c_valid;
        o_result.unit_kg        = i_frm.unit_kg;
        o_result.weight_changed = c_valid && (c_wm != r_last_w);
        o_result.tare_changed   = c_valid && (c_tm != r_last_t);
        o_result.unit_changed   = (i_frm.unit_kg != r_last_unit);
    end

    assign o_take = i_frm_valid && !i_buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_w    <= '0;
            r_last_t    <= '0;
            r_last_unit <= 1'b0;
        end else if (o_take) begin
            r_last_unit <= i_frm.unit_kg;
            if (c_valid) begin
                r_last_w <= c_wm;
                r_last_t <= c_tm;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sws_out_buf.sv -----
// Two-entry output register with skid stage for result items.
// Depends on sws_pkg for the result type.
`default_nettype none

module sws_out_buf
    import sws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_valid,
    output logic         o_full,
    output t_result      o_data
);

    logic    r_hv, r_sv;
    t_result r_head, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (i_pop) begin
            if (r_sv) begin
                r_sv <= i_push;
            end else begin
                r_hv <= i_push;
            end
        end else if (i_push) begin
            if (r_hv) begin
                r_sv <= 1'b1;
            end else begin
                r_hv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_sv) begin
                r_head <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_hv) begin
                r_skid <= i_data;
            end else begin
                r_head <= i_data;
            end
        end
    end

    assign o_valid = r_hv;
    assign o_full  = r_sv;
    assign o_data  = r_head;

endmodule

`default_nettype wire

// ----- rtl/scale_weight_frame_parser.sv -----
// Top level of the weighing scale frame parser: byte stream in, one result item per good frame.
// Depends on sws_pkg, sws_parser, sws_publish and sws_out_buf.
//
// The block takes one received byte per clock cycle while input ready is high. A 0x02 byte
// starts an 18-byte frame; a frame whose 7-bit sum is zero and whose status B bit 2 is clear
// yields one result item, held first in the parser's frame register and then in the output
// buffer. Input ready drops only while a finished frame waits and both entries of the output
// buffer are occupied, which takes a stalled consumer over several whole frames.
`default_nettype none

module scale_weight_frame_parser
    import sws_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // [7:0] rx_byte
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    // [19:0] weight_raw, [39:20] tare_raw, [41:40] decimals, [44:42] mode_code,
    // [45] value_valid, [46] unit_kg, [47] weight_changed, [48] tare_changed,
    // [49] unit_changed, [55:50] zero
    output logic [TDATA_W-1:0]      o_m_tdata
);

    logic    w_frm_valid;
    t_frame  w_frm;
    logic    w_take;
    logic    w_full;
    t_result w_result;
    t_result w_out;

    assign o_s_tready = !(w_frm_valid && w_full);

    sws_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid && o_s_tready),
        .i_byte      (i_s_tdata),
        .i_take      (w_take),
        .o_frm_valid (w_frm_valid),
        .o_frm       (w_frm)
    );

    sws_publish u_publish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_valid (w_frm_valid),
        .i_frm       (w_frm),
        .i_buf_full  (w_full),
        .o_take      (w_take),
        .o_result    (w_result)
    );

    sws_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_data  (w_result),
        .i_pop   (o_m_tvalid && i_m_tready),
        .o_valid (o_m_tvalid),
        .o_full  (w_full),
        .o_data  (w_out)
    );

    assign o_m_tdata = {6'd0, w_out};

endmodule

`default_nettype wire

// ----- verif/scale_weight_frame_parser_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for scale_weight_frame_parser: serial frames go in as byte items,
// a scoreboard predicts every published frame result and compares it field by field.
// Depends on sws_pkg and the RTL of the block.

import sws_pkg::*;

localparam int RESULT_W = $bits(t_result);

class frame_scoreboard;
    t_result            expected_frames[$];
    int                 errors;
    bit                 in_frame;
    logic [4:0]         pos;
    logic [6:0]         sum;
    logic [2:0]         status_a;
    logic               status_b_bad;
    logic               status_b_kg;
    t_num               weight;
    t_num               tare;
    logic [MILLI_W-1:0] last_weight_milli;
    logic [MILLI_W-1:0] last_tare_milli;
    logic               last_unit_kg;

    function new();
        errors = 0;
        in_frame = 1'b0;
        pos = '0;
        sum = '0;
        status_a = '0;
        status_b_bad = 1'b0;
        status_b_kg = 1'b0;
        weight = '0;
        tare = '0;
        last_weight_milli = '0;
        last_tare_milli = '0;
        last_unit_kg = 1'b0;
    endfunction

    function t_num feed_digit(logic [7:0] b, t_num cur);
        t_num        nxt;
        logic [31:0] tmp;
        nxt = cur;
        if (!cur.stopped) begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                tmp = cur.acc * 10 + (b - ASCII_ZERO);
                nxt.acc = tmp[VALUE_W-1:0];
                nxt.started = 1'b1;
            end else if (!(b == ASCII_SPACE && !cur.started)) begin
                nxt.stopped = 1'b1;
            end
        end
        return nxt;
    endfunction

    function void note_byte(logic [7:0] b);
        t_result     r;
        logic [31:0] mul;
        logic [31:0] wm;
        logic [31:0] tm;
        if (b == FRAME_START) begin
            in_frame = 1'b1;
            pos = '0;
            sum = '0;
            status_a = '0;
            status_b_bad = 1'b0;
            status_b_kg = 1'b0;
            weight = '0;
            tare = '0;
        end
        if (!in_frame) return;
        sum = sum + b[6:0];
        if (pos == POS_STATUS_A) begin
            status_a = b[2:0];
        end else if (pos == POS_STATUS_B) begin
            status_b_bad = b[2];
            status_b_kg = b[4];
        end else if (pos >= POS_WEIGHT_HEAD && pos <= POS_WEIGHT_TAIL) begin
            weight = feed_digit(b, weight);
        end else if (pos >= POS_TARE_HEAD && pos <= POS_TARE_TAIL) begin
            tare = feed_digit(b, tare);
        end
        pos = pos + 1'b1;
        if (pos != FRAME_LEN) return;
        in_frame = 1'b0;
        pos = '0;
        if (sum != '0 || status_b_bad) begin
            sum = '0;
            return;
        end
        sum = '0;
        r = '0;
        r.weight_raw = weight.acc;
        r.tare_raw = tare.acc;
        r.mode_code = status_a;
        r.unit_kg = status_b_kg;
        case (status_a)
            MODE_ONE_DEC: begin
                r.decimals = 2'd1;
                mul = 100;
            end
            MODE_TWO_DEC: begin
                r.decimals = 2'd2;
                mul = 10;
            end
            MODE_THREE_DEC: begin
                r.decimals = 2'd3;
                mul = 1;
            end
            default: begin
                mul = 0;
            end
        endcase
        r.value_valid = (mul != 0);
        if (r.value_valid) begin
            wm = weight.acc * mul;
            tm = tare.acc * mul;
            r.weight_changed = (wm[MILLI_W-1:0] != last_weight_milli);
            r.tare_changed = (tm[MILLI_W-1:0] != last_tare_milli);
            last_weight_milli = wm[MILLI_W-1:0];
            last_tare_milli = tm[MILLI_W-1:0];
        end
        r.unit_changed = (status_b_kg != last_unit_kg);
        last_unit_kg = status_b_kg;
        expected_frames.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(logic [TDATA_W-1:0] d);
        t_result got;
        t_result want;
        got = d[RESULT_W-1:0];
        if (expected_frames.size() == 0) begin
            $error("result item with no frame pending: tdata %h", d);
            errors++;
            return;
        end
        want = expected_frames.pop_front();
        check_field("weight_raw", want.weight_raw, got.weight_raw);
        check_field("tare_raw", want.tare_raw, got.tare_raw);
        check_field("decimals", want.decimals, got.decimals);
        check_field("mode_code", want.mode_code, got.mode_code);
        check_field("value_valid", want.value_valid, got.value_valid);
        check_field("unit_kg", want.unit_kg, got.unit_kg);
        check_field("weight_changed", want.weight_changed, got.weight_changed);
        check_field("tare_changed", want.tare_changed, got.tare_changed);
        check_field("unit_changed", want.unit_changed, got.unit_changed);
        check_field("padding", 0, d[TDATA_W-1:RESULT_W]);
    endfunction
endclass

module scale_weight_frame_parser_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HELD} t_rx_style;
    typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_STATUS, FR_CUT, FR_NOISE} t_frame_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic [7:0]         i_s_tdata = '0;
    logic               i_m_tready = 1'b0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [TDATA_W-1:0] o_m_tdata;

    frame_scoreboard    sb;
    bit                 in_fire = 1'b0;
    int                 burst_left = 0;
    int                 bytes_sent = 0;
    int                 cycle_count = 0;
    t_rx_style          rx_style = RX_OPEN;
    int                 rx_left = 0;
    logic [47:0]        last_weight_txt = {6{ASCII_SPACE}};
    logic [47:0]        last_tare_txt = {6{ASCII_SPACE}};

    scale_weight_frame_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
        if (in_fire) begin
            sb.note_byte(i_s_tdata);
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_style)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_MOSTLY: i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= 1'b0;
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] clean(input logic [7:0] b);
        return (b == FRAME_START) ? (b | 8'h80) : b;
    endfunction

    function automatic logic [7:0] rand_byte();
        return clean(8'($urandom_range(0, 255)));
    endfunction

    // Lead spaces, then nd digits of value, then a terminator if room is left, and random tail bytes.
    function automatic logic [47:0] number_text(input int unsigned value, input int nd,
                                                input int lead);
        logic [47:0] t;
        logic [7:0]  stop_b;
        int unsigned v;
        v = value;
        for (int i = 0; i < 6; i++) t[8*i +: 8] = rand_byte();
        for (int i = 0; i < lead; i++) t[8*i +: 8] = ASCII_SPACE;
        for (int i = nd - 1; i >= 0; i--) begin
            t[8*(lead+i) +: 8] = 8'(ASCII_ZERO + v % 10);
            v = v / 10;
        end
        if (lead + nd < 6) begin
            stop_b = rand_byte();
            if ((stop_b >= ASCII_ZERO && stop_b <= ASCII_NINE) || $urandom_range(0, 2) == 0) begin
                stop_b = $urandom_range(0, 1) ? 8'h2E : ASCII_SPACE;
            end
            t[8*(lead+nd) +: 8] = stop_b;
        end
        return t;
    endfunction

    function automatic logic [47:0] random_number_text();
        logic [47:0] t;
        int          nd;
        int          lead;
        int unsigned limit;
        case ($urandom_range(0, 9))
            0: begin
                for (int i = 0; i < 6; i++) t[8*i +: 8] = rand_byte();
            end
            1: begin
                t = {6{ASCII_SPACE}};
            end
            default: begin
                nd = $urandom_range(0, 6);
                lead = $urandom_range(0, 1) ? 6 - nd : $urandom_range(0, 6 - nd);
                limit = 1;
                for (int i = 0; i < nd; i++) limit = limit * 10;
                t = number_text($urandom_range(0, 4) == 0 ? limit - 1 : $urandom_range(0, limit - 1),
                                nd, lead);
            end
        endcase
        return t;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        do @(negedge i_clk); while (!in_fire);
    endtask

    task automatic send_frame(input logic [7:0] status_a, input logic [7:0] status_b,
                              input logic [47:0] wtxt, input logic [47:0] ttxt,
                              input bit bad_sum, input int count);
        logic [7:0] fb [18];
        logic [6:0] fsum;
        fb[0] = FRAME_START;
        fb[1] = clean(status_a);
        fb[2] = clean(status_b);
        fb[3] = rand_byte();
        for (int i = 0; i < 6; i++) begin
            fb[4+i] = clean(wtxt[8*i +: 8]);
            fb[10+i] = clean(ttxt[8*i +: 8]);
        end
        fb[16] = $urandom_range(0, 1) ? 8'h0D : rand_byte();
        fsum = '0;
        for (int i = 0; i < 17; i++) fsum = fsum + fb[i][6:0];
        fb[17] = {$urandom_range(0, 1) == 1, ~fsum + 7'd1};
        if (bad_sum) fb[17] = fb[17] ^ (8'h01 << $urandom_range(0, 6));
        fb[17] = clean(fb[17]);
        for (int i = 0; i < count; i++) begin
            send_byte(fb[i]);
            bytes_sent++;
        end
    endtask

    task automatic random_frame();
        int          pick;
        t_frame_kind kind;
        logic [7:0]  stat_a;
        logic [7:0]  stat_b;
        logic [47:0] wtxt;
        logic [47:0] ttxt;
        pick = $urandom_range(0, 99);
        kind = (pick < 72) ? FR_GOOD : (pick < 82) ? FR_BAD_SUM :
               (pick < 88) ? FR_BAD_STATUS : (pick < 95) ? FR_CUT : FR_NOISE;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            return;
        end
        stat_a = 8'($urandom_range(0, 255));
        stat_a[2:0] = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(3, 5))
                                                 : 3'($urandom_range(0, 7));
        stat_b = 8'($urandom_range(0, 255));
        stat_b[2] = (kind == FR_BAD_STATUS);
        wtxt = ($urandom_range(0, 3) == 0) ? last_weight_txt : random_number_text();
        ttxt = ($urandom_range(0, 2) == 0) ? last_tare_txt : random_number_text();
        last_weight_txt = wtxt;
        last_tare_txt = ttxt;
        send_frame(stat_a, stat_b, wtxt, ttxt, kind == FR_BAD_SUM,
                   (kind == FR_CUT) ? $urandom_range(1, 17) : 18);
    endtask

    task automatic pause_until_drained();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_frames.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes outside a frame are ignored.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_frame(8'h33, 8'h10, number_text(999999, 6, 0), number_text(0, 6, 0), 0, 18);
        send_frame(8'h34, 8'h00, number_text(1234, 4, 2), number_text(12, 2, 4), 0, 18);
        // Same values in thousandths as the previous frame; only the unit change is flagged.
        send_frame(8'h35, 8'h10, number_text(12340, 5, 1), number_text(120, 3, 3), 0, 18);
        send_frame(8'h30, 8'h10, number_text(55, 2, 4), number_text(7, 1, 5), 0, 18);
        send_frame(8'h37, 8'hEB, {6{ASCII_SPACE}}, number_text(0, 6, 0), 0, 18);
        send_frame(8'h32, 8'h10, number_text(12, 2, 0), number_text(3, 1, 1), 0, 18);
        send_frame(8'h33, 8'h10, number_text(1, 1, 0), number_text(2, 1, 0), 1, 18);
        send_frame(8'h33, 8'h14, number_text(5, 1, 5), number_text(6, 1, 5), 0, 18);
        // A frame cut short by a new start byte.
        send_frame(8'h34, 8'h10, number_text(77, 2, 4), number_text(1, 1, 5), 0, 9);
        send_frame(8'hCB, 8'hFB, number_text(0, 0, 0), number_text(42, 2, 0), 0, 18);
        send_frame(8'h36, 8'h00, number_text(321, 3, 3), number_text(9, 1, 5), 0, 18);
        send_frame(8'hB1, 8'h10, number_text(8, 1, 5), number_text(0, 0, 6), 0, 18);
        pause_until_drained();

        while (bytes_sent < 850) begin
            if ($urandom_range(0, 19) == 0) pause_until_drained();
            random_frame();
        end

        i_s_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
